FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the span fill block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/sf_pkg.sv
// Constants, word types and opcodes of the scan-line span fill block.
// Depends on nothing.
package sf_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int COORD_BITS   = 9;
  localparam int FRAC_BITS    = 8;
  localparam int MAX_SPANS    = 16;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int XING_W = COORD_BITS + FRAC_BITS;
  localparam int NUM_W  = 2 * COORD_BITS + FRAC_BITS;
  localparam int SPAN_W = $clog2(MAX_SPANS + 1);
  localparam int KIDX_W = $clog2(MAX_SPANS);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  span_valid;
    logic [COORD_BITS-1:0] span_row;
    logic [COORD_BITS-1:0] span_start;
    logic [COORD_BITS-1:0] span_end;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      num;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [XING_W-1:0] quo;
    logic              rem_nz;
  } div_rsp_t;
endpackage

FILE: hdl/sf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/sf_div.sv
// Restoring divider, one quotient bit per cycle, for edge crossings.
// Depends on sf_pkg. The quotient is known to fit in XING_W bits.
module sf_div
  import sf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [COORD_BITS-1:0] rem;
  logic [XING_W-1:0]     sh;
  logic [COORD_BITS-1:0] den;
  logic [SPAN_W:0]       cnt;
  logic                  run;
  logic                  done;
  logic [COORD_BITS:0]   trial;

  assign trial = {rem, sh[XING_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
        den <= req.den;
        rem <= req.num[NUM_W-1:XING_W];
        sh  <= req.num[XING_W-1:0];
      end else if (run) begin
        // shift in one numerator bit, subtract when it fits
        if (trial >= {1'b0, den}) begin
          rem <= COORD_BITS'(trial - {1'b0, den});
          sh  <= {sh[XING_W-2:0], 1'b1};
        end else begin
          rem <= trial[COORD_BITS-1:0];
          sh  <= {sh[XING_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == (SPAN_W+1)'(XING_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.quo    = sh;
  assign rsp.rem_nz = |rem;
endmodule

FILE: hdl/scanline_polygon_span_fill.sv
// Scan-line polygon span fill: vertex store, edge walk, sorted crossing buffer.
// Each command gives a burst of one-cycle results on valid; the receiver cannot
// stall, so results are never held. Clear, append, no-op and short queries give
// their one result word without leaving idle. A query walks every edge through
// fetch, edge test and next; an active edge adds a 9x9 multiply, a divider
// start, the divider run and the insert, plus a shift for each crossing buffer
// entry moved up. Each span is then output once the buffer's single read port
// has fetched both ends. busy stays high throughout a query.
// Depends on sf_pkg, sf_ram, sf_div and assert_macros.svh.
`include "assert_macros.svh"
module scanline_polygon_span_fill
  import sf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    valid,
  output result_t result
);
  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_FETCH, S_EDGE, S_MUL, S_DSTART, S_DIV, S_INS, S_SHIFT,
    S_PLACE, S_NEXT, S_OUT, S_EA, S_EB, S_EC
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [COORD_BITS-1:0] row;
  logic [ADDR_W-1:0]     vi;
  logic [COORD_BITS-1:0] first_x, first_y, cur_x, cur_y, nb_x, nb_y;
  logic [COORD_BITS-1:0] ady, add, adx;
  logic                  neg;
  logic [2*COORD_BITS-1:0] prod;
  logic [XING_W-1:0]     xc;
  logic [CNT_W-1:0]      n, p;
  logic [KIDX_W-1:0]     k;
  logic [SPAN_W-1:0]     pairs;
  logic [COORD_BITS-1:0] span_s;
  logic [1:0]            cmd_status;

  logic                    v_we;
  logic [ADDR_W-1:0]       v_raddr;
  logic [2*COORD_BITS-1:0] v_rdata;
  logic                    b_we;
  logic [ADDR_W-1:0]       b_waddr, b_raddr;
  logic [XING_W-1:0]       b_wdata, b_rdata;
  div_req_t                dreq;
  div_rsp_t                drsp;

  logic                  edge_last;
  logic [COORD_BITS-1:0] b_x, b_y, lo, hi;
  logic [CNT_W-1:0]      pairs_full;
  logic [XING_W-1:0]     base, xnew;
  logic [COORD_BITS:0]   e_full;

  assign busy = (state != S_IDLE);
  assign edge_last = (CNT_W'(vi) + 1'b1 == count);
  assign b_x = edge_last ? first_x : v_rdata[2*COORD_BITS-1:COORD_BITS];
  assign b_y = edge_last ? first_y : v_rdata[COORD_BITS-1:0];
  assign lo  = (cur_y < b_y) ? cur_y : b_y;
  assign hi  = (cur_y < b_y) ? b_y : cur_y;
  assign pairs_full = n >> 1;
  assign base = {cur_x, FRAC_BITS'(0)};
  assign xnew = neg ? base - drsp.quo - XING_W'(drsp.rem_nz) : base + drsp.quo;
  assign e_full = {1'b0, b_rdata[XING_W-1:FRAC_BITS]} + 1'b1;

  always_comb begin
    cmd_status = ST_OK;
    if (cmd.op == OP_APPEND && count >= CNT_W'(MAX_VERTICES)) cmd_status = ST_FULL;
    else if (cmd.op == OP_QUERY && count < CNT_W'(3)) cmd_status = ST_SHORT;
    v_we    = start && !busy && cmd.op == OP_APPEND && count < CNT_W'(MAX_VERTICES);
    v_raddr = (state == S_FETCH) ? ADDR_W'(CNT_W'(vi) + 1'b1) : '0;
    b_we    = 1'b0;
    b_waddr = p[ADDR_W-1:0];
    b_wdata = xc;
    b_raddr = '0;
    dreq.start = (state == S_DSTART);
    dreq.num   = {prod, FRAC_BITS'(0)};
    dreq.den   = add;
    unique case (state)
      S_INS: begin
        if (n == '0) begin
          b_we    = 1'b1;
          b_waddr = '0;
        end else begin
          b_raddr = ADDR_W'(n - 1'b1);
        end
      end
      S_SHIFT: begin
        b_we = 1'b1;
        if (b_rdata > xc) begin
          b_wdata = b_rdata;
          b_raddr = ADDR_W'(p - 2'd2);
        end
      end
      S_PLACE: begin
        b_we    = 1'b1;
        b_waddr = '0;
      end
      S_EA:    b_raddr = ADDR_W'({k, 1'b0});
      S_EB:    b_raddr = ADDR_W'({k, 1'b1});
      default: ;
    endcase
  end

  sf_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_VERTICES)) u_vram (
    .clk, .we(v_we), .waddr(count[ADDR_W-1:0]), .wdata({cmd.coord_x, cmd.coord_y}),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  sf_ram #(.WIDTH(XING_W), .DEPTH(MAX_VERTICES)) u_xbuf (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  sf_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            result <= '{status: cmd_status, span_valid: 1'b0, span_row: '0,
                        span_start: '0, span_end: '0, last: 1'b1};
            unique case (cmd.op)
              OP_CLEAR: begin
                count <= '0;
                valid <= 1'b1;
              end
              OP_APPEND: begin
                valid <= 1'b1;
                if (count < CNT_W'(MAX_VERTICES)) count <= count + 1'b1;
              end
              OP_QUERY: begin
                if (count < CNT_W'(3)) begin
                  valid <= 1'b1;
                end else begin
                  row   <= cmd.coord_y;
                  vi    <= '0;
                  n     <= '0;
                  state <= S_FIRST;
                end
              end
              OP_NONE: valid <= 1'b1;
              default: valid <= 1'b1;
            endcase
          end
        end
        S_FIRST: begin
          first_x <= v_rdata[2*COORD_BITS-1:COORD_BITS];
          first_y <= v_rdata[COORD_BITS-1:0];
          cur_x   <= v_rdata[2*COORD_BITS-1:COORD_BITS];
          cur_y   <= v_rdata[COORD_BITS-1:0];
          state   <= S_FETCH;
        end
        S_FETCH: state <= S_EDGE;
        S_EDGE: begin
          nb_x <= b_x;
          nb_y <= b_y;
          if (lo < row && row <= hi) begin
            ady <= (cur_y < b_y) ? row - cur_y : cur_y - row;
            add <= hi - lo;
            neg <= (b_x < cur_x);
            adx <= (b_x < cur_x) ? cur_x - b_x : b_x - cur_x;
            state <= S_MUL;
          end else begin
            state <= S_NEXT;
          end
        end
        S_MUL: begin
          prod  <= ady * adx;
          state <= S_DSTART;
        end
        // hand the registered product to the divider
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (drsp.done) begin
            xc    <= xnew;
            state <= S_INS;
          end
        end
        S_INS: begin
          if (n == '0) begin
            n     <= n + 1'b1;
            state <= S_NEXT;
          end else begin
            p     <= n;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // move larger entries up one slot, stop at the first that is not
          if (b_rdata > xc) begin
            p <= p - 1'b1;
            if (p == CNT_W'(1)) state <= S_PLACE;
          end else begin
            n     <= n + 1'b1;
            state <= S_NEXT;
          end
        end
        S_PLACE: begin
          n     <= n + 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          cur_x <= nb_x;
          cur_y <= nb_y;
          if (edge_last) begin
            state <= S_OUT;
          end else begin
            vi    <= vi + 1'b1;
            state <= S_FETCH;
          end
        end
        S_OUT: begin
          k <= '0;
          if (pairs_full > CNT_W'(MAX_SPANS)) pairs <= SPAN_W'(MAX_SPANS);
          else pairs <= SPAN_W'(pairs_full);
          if (pairs_full == '0) begin
            result <= '{status: ST_OK, span_valid: 1'b0, span_row: '0,
                        span_start: '0, span_end: '0, last: 1'b1};
            valid  <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_EA;
          end
        end
        S_EA: state <= S_EB;
        S_EB: begin
          span_s <= b_rdata[XING_W-1:FRAC_BITS];
          state  <= S_EC;
        end
        S_EC: begin
          result.status     <= ST_OK;
          result.span_valid <= 1'b1;
          result.span_row   <= row;
          result.span_start <= span_s;
          result.span_end   <= e_full[COORD_BITS] ? '1 : e_full[COORD_BITS-1:0];
          result.last       <= (SPAN_W'(k) + 1'b1 == pairs);
          valid             <= 1'b1;
          if (SPAN_W'(k) + 1'b1 == pairs) state <= S_IDLE;
          else begin
            k     <= k + 1'b1;
            state <= S_EA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SF_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CNT_W'(MAX_VERTICES))
  `SF_ASSERT_IMPL(a_n_le_count, clk, rst, busy, n <= count)
  `SF_ASSERT_IMPL(a_last_frees, clk, rst, valid && result.last, !busy)
  `SF_ASSERT_IMPL(a_span_order, clk, rst, valid && result.span_valid,
                  result.span_start <= result.span_end)
endmodule

FILE: tb/sv/sf_checker.sv
// Checker for the scan-line span fill block: predicts every result word of each
// accepted command and compares it with the block's output. Depends on sf_pkg.
`timescale 1ns / 100ps
module sf_checker
  import sf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    valid,
  input  result_t result,
  output int      fail_count,
  output int      pending_count,
  output int      span_count
);
  logic [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  int unsigned           poly_n;
  result_t               span_queue [$];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic result_t status_word(logic [1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_spans(logic [COORD_BITS-1:0] y);
    longint xs [$];
    longint xa, ya, xb, yb, lo, hi, x;
    int unsigned j, pairs, p;
    result_t r;
    for (int unsigned i = 0; i < poly_n; i++) begin
      j = (i + 1 < poly_n) ? i + 1 : 0;
      xa = poly_x[i]; ya = poly_y[i]; xb = poly_x[j]; yb = poly_y[j];
      lo = (ya < yb) ? ya : yb;
      hi = (ya < yb) ? yb : ya;
      if (!(lo < y && y <= hi)) continue;
      x = xa * 256 + floor_quot((longint'(y) - ya) * (xb - xa) * 256, yb - ya);
      if (x < 0) x = 0;
      // insert after equal keys so ties keep edge order
      p = xs.size();
      while (p > 0 && xs[p-1] > x) p--;
      xs.insert(p, x);
    end
    pairs = xs.size() / 2;
    if (pairs > MAX_SPANS) pairs = MAX_SPANS;
    if (pairs == 0) begin
      span_queue.push_back(status_word(ST_OK));
      return;
    end
    for (int unsigned k = 0; k < pairs; k++) begin
      r = '0;
      r.span_valid = 1'b1;
      r.span_row = y;
      x = xs[2*k] >>> FRAC_BITS;
      r.span_start = (x > 511) ? 9'd511 : x[8:0];
      x = (xs[2*k+1] >>> FRAC_BITS) + 1;
      r.span_end = (x > 511) ? 9'd511 : x[8:0];
      r.last = (k + 1 == pairs);
      span_queue.push_back(r);
    end
  endtask

  assign pending_count = span_queue.size();

  always @(posedge clk) begin
    result_t exp_w;
    if (rst) begin
      poly_n <= 0;
      fail_count <= 0;
      span_count <= 0;
    end else begin
      if (valid) begin
        if (span_queue.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = span_queue.pop_front();
          if (result.span_valid) span_count <= span_count + 1;
          if (result !== exp_w) begin
            fail_count <= fail_count + 1;
            if (result.status !== exp_w.status)
              $error("status exp %0d got %0d", exp_w.status, result.status);
            if (result.span_valid !== exp_w.span_valid)
              $error("span_valid exp %0d got %0d", exp_w.span_valid, result.span_valid);
            if (result.span_row !== exp_w.span_row)
              $error("span_row exp %0d got %0d", exp_w.span_row, result.span_row);
            if (result.span_start !== exp_w.span_start)
              $error("span_start exp %0d got %0d", exp_w.span_start, result.span_start);
            if (result.span_end !== exp_w.span_end)
              $error("span_end exp %0d got %0d", exp_w.span_end, result.span_end);
            if (result.last !== exp_w.last)
              $error("last exp %0d got %0d", exp_w.last, result.last);
          end
        end
      end
      if (start && !busy) begin
        case (cmd.op)
          OP_CLEAR: begin
            poly_n = 0;
            span_queue.push_back(status_word(ST_OK));
          end
          OP_APPEND: begin
            if (poly_n >= MAX_VERTICES) begin
              span_queue.push_back(status_word(ST_FULL));
            end else begin
              poly_x[poly_n] = cmd.coord_x;
              poly_y[poly_n] = cmd.coord_y;
              poly_n = poly_n + 1;
              span_queue.push_back(status_word(ST_OK));
            end
          end
          OP_QUERY: begin
            if (poly_n < 3) span_queue.push_back(status_word(ST_SHORT));
            else predict_spans(cmd.coord_y);
          end
          default: span_queue.push_back(status_word(ST_OK));
        endcase
      end
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Top of the span fill testbench: clock, reset, command stimulus and verdict.
// Depends on sf_pkg, sf_checker and the scanline_polygon_span_fill block.
`timescale 1ns / 100ps
module tb_top;
  import sf_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    valid;
  result_t result;
  int      fail_count, pending_count, span_count;
  int      sent;
  bit      quiet_tail;

  always #4 clk = ~clk;

  scanline_polygon_span_fill i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .valid(valid), .result(result)
  );

  sf_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .valid(valid), .result(result), .fail_count(fail_count),
    .pending_count(pending_count), .span_count(span_count)
  );

  // Drive one word and hold it until accepted, with an optional idle burst first.
  task automatic send_word(logic [1:0] op, logic [8:0] x, logic [8:0] y);
    if (!quiet_tail && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{op: op, coord_x: x, coord_y: y};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic load_polygon(int unsigned nv, int unsigned span);
    int unsigned bx, by;
    send_word(OP_CLEAR, 9'($urandom), 9'($urandom));
    bx = $urandom_range(511 - span);
    by = $urandom_range(511 - span);
    for (int unsigned v = 0; v < nv; v++)
      send_word(OP_APPEND, 9'(bx + $urandom_range(span)), 9'(by + $urandom_range(span)));
  endtask

  initial begin
    int unsigned nv, span;
    sent = 0;
    quiet_tail = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: short polygon, extremes, vertical edge, op 3
    send_word(OP_QUERY, 9'd100, 9'd100);
    send_word(OP_APPEND, 9'd0, 9'd0);
    send_word(OP_APPEND, 9'd511, 9'd0);
    send_word(OP_QUERY, 9'd0, 9'd0);
    send_word(OP_APPEND, 9'd511, 9'd511);
    send_word(OP_APPEND, 9'd0, 9'd511);
    send_word(OP_QUERY, 9'd0, 9'd1);
    send_word(OP_QUERY, 9'd511, 9'd511);
    send_word(OP_QUERY, 9'd0, 9'd0);
    send_word(OP_NONE, 9'd511, 9'd511);
    send_word(OP_CLEAR, 9'd511, 9'd511);
    send_word(OP_APPEND, 9'd10, 9'd5);
    send_word(OP_APPEND, 9'd300, 9'd5);
    send_word(OP_APPEND, 9'd20, 9'd200);
    send_word(OP_QUERY, 9'd0, 9'd100);
    // zigzag of 32 vertices: sixteen pairs of crossings, then a dropped vertex
    send_word(OP_CLEAR, 9'd0, 9'd0);
    for (int v = 0; v < 32; v++)
      send_word(OP_APPEND, 9'(v * 16), (v % 2) ? 9'd400 : 9'd10);
    send_word(OP_APPEND, 9'd5, 9'd5);
    send_word(OP_QUERY, 9'd0, 9'd200);
    send_word(OP_QUERY, 9'd0, 9'd400);
    // random polygons with queries at random rows, plus some noise words
    while (sent < 210) begin
      if (sent > 170) quiet_tail = 1;
      nv = ($urandom_range(7) == 0) ? $urandom_range(33, 2) : $urandom_range(8, 3);
      span = ($urandom_range(3) == 0) ? 511 : $urandom_range(200, 8);
      load_polygon(nv, span);
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(9) == 0) send_word(2'($urandom), 9'($urandom), 9'($urandom));
        else send_word(OP_QUERY, 9'($urandom), 9'($urandom));
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d command words; %0d fill spans checked.", sent, span_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
